@@ hdl/sector_cache_clock_replacer_defines.svh @@
// assertion macros for the sector cache clock replacer
// used by the top level, which supplies clk and arst_n in scope
`ifndef SECTOR_CACHE_CLOCK_REPLACER_DEFINES_SVH
`define SECTOR_CACHE_CLOCK_REPLACER_DEFINES_SVH

`ifndef SYNTH
`define SCCR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sccr: same-cycle check failed");
`define SCCR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sccr: next-cycle check failed");
`else
`define SCCR_ASSERT_IMP(name, ante, cons)
`define SCCR_ASSERT_NXT(name, ante, cons)
`endif

`endif

@@ hdl/sccr_pkg.sv @@
// shared types and constants for the sector cache clock replacer
// no dependencies
package sccr_pkg;

	localparam int CMD_W    = 2;
	localparam int SECTOR_W = 32;
	localparam int OFS_W    = 10;
	localparam int SLOT_W   = 6;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FLUSH = 2'd2
	} sccr_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_VICTIM,
		ST_FINISH,
		ST_FLUSH,
		ST_FL_EMIT
	} sccr_state_t;

endpackage

@@ hdl/sccr_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module sccr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/sector_cache_clock_replacer.sv @@
// sector cache tag lookup and second-chance clock replacement
// hit: serial tag ram scan stops at the first match; miss: full scan, then the clock sweep picks a victim
// flush: entries are scanned from the hand and each dirty entry is reported in turn
// one request at a time; in_stall holds new requests through the serial tag ram scan and the ring sweep
// reset clears valid, accessed and dirty marks and the hand; tag ram is not cleared
// depends on sccr_pkg, sccr_ram and sector_cache_clock_replacer_defines.svh
`include "sector_cache_clock_replacer_defines.svh"

module sector_cache_clock_replacer #(
	parameter int ENTRIES      = 64,
	parameter int SECTOR_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sccr_pkg::CMD_W-1:0]    cmd,
	input  logic [sccr_pkg::SECTOR_W-1:0] sector,
	input  logic [sccr_pkg::OFS_W-1:0]    byte_offset,
	input  logic [sccr_pkg::OFS_W-1:0]    byte_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [sccr_pkg::SLOT_W-1:0]   slot,
	output logic                          fetch,
	output logic                          writeback,
	output logic [sccr_pkg::SECTOR_W-1:0] writeback_sector,
	output logic                          last
);

	import sccr_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(2 * ENTRIES + 2);

	function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] e);
		ring_inc = (e == IDX_W'(ENTRIES - 1)) ? '0 : e + 1'b1;
	endfunction

	sccr_state_t state_q, state_d;

	logic [ENTRIES-1:0]  valid_q, acc_q, dirty_q;
	logic [IDX_W-1:0]    hand_q;
	logic [SECTOR_W-1:0] sector_q;
	logic                write_q, full_q;
	logic [CNT_W-1:0]    scan_q, passes_q, dirty_cnt_q;
	logic                cmp_vld_s1;
	logic [IDX_W-1:0]    cmp_idx_s1;
	logic [IDX_W-1:0]    slot_q, fidx_q;
	logic                lookup_hit_q;

	logic                out_valid_q, out_hit_q, out_fetch_q, out_wb_q, out_last_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [SECTOR_W-1:0] out_wbs_q;

	logic                in_xfer, out_free, out_load;
	logic                hit_now, miss_now, issue_en;
	logic                acc_e, dty_e, late_pass, take_now, skip_take, clear_acc;
	logic [IDX_W-1:0]    hand_inc, victim;
	logic                flush_last;
	logic [IDX_W-1:0]    ram_raddr;
	logic                ram_we;
	logic [SECTOR_W-1:0] ram_rdata;
	logic                ld_hit, ld_fetch, ld_wb, ld_last;
	logic [IDX_W-1:0]    ld_slot;
	logic [SECTOR_W-1:0] ld_wbs;

	sccr_ram #(.WIDTH(SECTOR_W), .DEPTH(ENTRIES)) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (sector_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign hit_now  = cmp_vld_s1 && valid_q[cmp_idx_s1] && (ram_rdata == sector_q);
	assign miss_now = cmp_vld_s1 && !hit_now && (cmp_idx_s1 == IDX_W'(ENTRIES - 1));
	assign issue_en = (state_q == ST_SEARCH) && (scan_q < CNT_W'(ENTRIES)) && !hit_now;

	// victim sweep at the hand
	assign acc_e     = acc_q[hand_q];
	assign dty_e     = dirty_q[hand_q];
	assign late_pass = (passes_q >= CNT_W'(ENTRIES - 1));
	assign skip_take = acc_e && late_pass && dty_e && (dirty_cnt_q >= CNT_W'(ENTRIES));
	assign take_now  = !acc_e || (late_pass && !dty_e) || skip_take;
	assign clear_acc = acc_e && !late_pass && !dty_e;
	assign hand_inc  = ring_inc(hand_q);
	assign victim    = skip_take ? hand_inc : hand_q;

	assign flush_last = ((dirty_q & ~(ENTRIES'(1) << fidx_q)) == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (cmd)
						CMD_READ, CMD_WRITE: state_d = ST_SEARCH;
						CMD_FLUSH:           state_d = ST_FLUSH;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEARCH: begin
				if (hit_now) begin
					state_d = ST_FINISH;
				end else if (miss_now) begin
					state_d = ST_VICTIM;
				end
			end
			ST_VICTIM: begin
				if (take_now) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (dirty_q == '0) begin
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else if (dirty_q[fidx_q]) begin
					state_d = ST_FL_EMIT;
				end
			end
			ST_FL_EMIT: begin
				if (out_free) begin
					state_d = flush_last ? ST_IDLE : ST_FLUSH;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath controls and result values
	always_comb begin
		ram_raddr = slot_q;
		ram_we    = 1'b0;
		out_load  = 1'b0;
		ld_hit    = 1'b0;
		ld_slot   = '0;
		ld_fetch  = 1'b0;
		ld_wb     = 1'b0;
		ld_wbs    = '0;
		ld_last   = 1'b1;
		case (state_q)
			ST_SEARCH: begin
				ram_raddr = scan_q[IDX_W-1:0];
			end
			ST_VICTIM: begin
				ram_raddr = victim;
			end
			ST_FINISH: begin
				ram_raddr = slot_q;
				out_load  = out_free;
				ram_we    = out_free && !lookup_hit_q;
				ld_hit    = lookup_hit_q;
				ld_slot   = slot_q;
				ld_fetch  = !lookup_hit_q && !full_q;
				ld_wb     = !lookup_hit_q && dirty_q[slot_q];
				ld_wbs    = ld_wb ? ram_rdata : '0;
			end
			ST_FLUSH: begin
				ram_raddr = fidx_q;
				out_load  = out_free && (dirty_q == '0);
			end
			ST_FL_EMIT: begin
				ram_raddr = fidx_q;
				out_load  = out_free;
				ld_slot   = fidx_q;
				ld_wb     = 1'b1;
				ld_wbs    = ram_rdata;
				ld_last   = flush_last;
			end
			default: begin
				ram_raddr = slot_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			acc_q       <= '0;
			dirty_q     <= '0;
			hand_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_VICTIM: begin
					hand_q <= skip_take ? ring_inc(hand_inc) : hand_inc;
					if (clear_acc) begin
						acc_q[hand_q] <= 1'b0;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						acc_q[slot_q] <= 1'b1;
						if (lookup_hit_q) begin
							dirty_q[slot_q] <= dirty_q[slot_q] | write_q;
						end else begin
							dirty_q[slot_q] <= write_q;
							valid_q[slot_q] <= 1'b1;
						end
					end
				end
				ST_FL_EMIT: begin
					if (out_free) begin
						dirty_q[fidx_q] <= 1'b0;
						acc_q[fidx_q]   <= 1'b0;
					end
				end
				default: begin
					hand_q <= hand_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sector_q    <= sector;
			write_q     <= (cmd == CMD_WRITE);
			full_q      <= (cmd == CMD_WRITE) && (byte_offset == '0) &&
				(32'(byte_count) >= 32'(SECTOR_BYTES));
			scan_q      <= '0;
			passes_q    <= '0;
			dirty_cnt_q <= '0;
			fidx_q      <= hand_q;
		end
		if (issue_en) begin
			scan_q     <= scan_q + 1'b1;
			cmp_idx_s1 <= scan_q[IDX_W-1:0];
		end
		if (state_q == ST_SEARCH && hit_now) begin
			slot_q       <= cmp_idx_s1;
			lookup_hit_q <= 1'b1;
		end
		if (state_q == ST_VICTIM) begin
			if (acc_e) begin
				passes_q <= passes_q + 1'b1;
			end
			if (acc_e && late_pass && dty_e) begin
				dirty_cnt_q <= dirty_cnt_q + 1'b1;
			end
			if (take_now) begin
				slot_q       <= victim;
				lookup_hit_q <= 1'b0;
			end
		end
		if (state_q == ST_FLUSH && dirty_q != '0 && !dirty_q[fidx_q]) begin
			fidx_q <= ring_inc(fidx_q);
		end
		if (state_q == ST_FL_EMIT && out_free) begin
			fidx_q <= ring_inc(fidx_q);
		end
		if (out_load) begin
			out_hit_q   <= ld_hit;
			out_slot_q  <= SLOT_W'(ld_slot);
			out_fetch_q <= ld_fetch;
			out_wb_q    <= ld_wb;
			out_wbs_q   <= ld_wbs;
			out_last_q  <= ld_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = out_hit_q;
	assign slot             = out_slot_q;
	assign fetch            = out_fetch_q;
	assign writeback        = out_wb_q;
	assign writeback_sector = out_wbs_q;
	assign last             = out_last_q;

	`SCCR_ASSERT_IMP(a_hit_no_disk, out_valid_q && out_hit_q, !out_fetch_q && !out_wb_q)
	`SCCR_ASSERT_IMP(a_wbs_zero, out_valid_q && !out_wb_q, out_wbs_q == '0)
	`SCCR_ASSERT_IMP(a_sweep_bound, state_q == ST_VICTIM, dirty_cnt_q <= CNT_W'(ENTRIES))
	`SCCR_ASSERT_NXT(a_flush_clean, out_load && state_q == ST_FL_EMIT && flush_last, dirty_q == '0)

endmodule

@@ sim/sector_cache_clock_replacer_test.sv @@
`timescale 1ns / 1ps
// testbench for sector_cache_clock_replacer: a shadow model of the tag store and clock hand
// predicts every result; directed, all-dirty and random requests under varied stalls
// depends on sccr_pkg and the block itself
module sector_cache_clock_replacer_test;
	import sccr_pkg::*;

	localparam int N_ENTRIES = 64;
	localparam int SECTOR_SIZE = 512;
	localparam int POOL_SIZE = 80;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	typedef struct {
		logic                hit;
		logic [SLOT_W-1:0]   slot;
		logic                fetch;
		logic                writeback;
		logic [SECTOR_W-1:0] writeback_sector;
		logic                last;
	} cache_result_t;

	class cache_tag_tracker;
		logic [SECTOR_W-1:0] tags [N_ENTRIES];
		bit present [N_ENTRIES];
		bit referenced [N_ENTRIES];
		bit modified [N_ENTRIES];
		int hand;
		cache_result_t owed_results [$];
		int errors, requests, results, hits, misses, flushes, writebacks;

		function new();
			foreach (present[i]) begin
				present[i] = 0;
				referenced[i] = 0;
				modified[i] = 0;
			end
			hand = 0;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function int step_hand();
			int e;
			e = hand;
			hand = (hand + 1) % N_ENTRIES;
			return e;
		endfunction

		function int pick_victim();
			int passes, dirty_seen, e;
			passes = 0;
			dirty_seen = 0;
			e = 0;
			for (int n = 0; n < 4 * N_ENTRIES + 4; n++) begin
				e = step_hand();
				if (!referenced[e])
					return e;
				passes++;
				if (passes < N_ENTRIES) begin
					if (!modified[e])
						referenced[e] = 0;
				end else if (!modified[e]) begin
					return e;
				end else begin
					dirty_seen++;
					if (dirty_seen > N_ENTRIES)
						return step_hand();
				end
			end
			return e;
		endfunction

		function void note_request(logic [CMD_W-1:0] op, logic [SECTOR_W-1:0] sec,
				logic [OFS_W-1:0] ofs, logic [OFS_W-1:0] cnt);
			cache_result_t r;
			int idx, e, ndirty, told;
			bit whole;
			requests++;
			r = '{hit: 1'b0, slot: '0, fetch: 1'b0, writeback: 1'b0,
				writeback_sector: '0, last: 1'b0};
			if (op == CMD_FLUSH) begin
				flushes++;
				ndirty = 0;
				told = 0;
				foreach (modified[i])
					if (modified[i])
						ndirty++;
				if (ndirty == 0) begin
					r.last = 1'b1;
					owed_results.push_back(r);
					return;
				end
				for (int i = 0; i < N_ENTRIES; i++) begin
					e = (hand + i) % N_ENTRIES;
					if (modified[e]) begin
						told++;
						r.slot = SLOT_W'(e);
						r.writeback = 1'b1;
						r.writeback_sector = tags[e];
						r.last = (told == ndirty);
						owed_results.push_back(r);
						writebacks++;
						modified[e] = 0;
						referenced[e] = 0;
					end
				end
				return;
			end
			if (op == CMD_NONE)
				return;
			idx = -1;
			for (int i = 0; i < N_ENTRIES; i++)
				if (idx < 0 && present[i] && tags[i] == sec)
					idx = i;
			r.last = 1'b1;
			if (idx >= 0) begin
				hits++;
				referenced[idx] = 1;
				if (op == CMD_WRITE)
					modified[idx] = 1;
				r.hit = 1'b1;
				r.slot = SLOT_W'(idx);
				owed_results.push_back(r);
				return;
			end
			misses++;
			whole = (op == CMD_WRITE) && ofs == 0 && cnt >= SECTOR_SIZE;
			e = pick_victim();
			if (modified[e]) begin
				writebacks++;
				r.writeback = 1'b1;
				r.writeback_sector = tags[e];
			end
			tags[e] = sec;
			present[e] = 1;
			referenced[e] = 1;
			modified[e] = (op == CMD_WRITE);
			r.slot = SLOT_W'(e);
			r.fetch = !whole;
			owed_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$error("%s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		function void check_result(cache_result_t got);
			cache_result_t want;
			results++;
			if (owed_results.size() == 0) begin
				errors++;
				$error("unexpected result: slot %0d last %0b", got.slot, got.last);
				return;
			end
			want = owed_results.pop_front();
			compare_field("hit", want.hit, got.hit);
			compare_field("slot", want.slot, got.slot);
			compare_field("fetch", want.fetch, got.fetch);
			compare_field("writeback", want.writeback, got.writeback);
			compare_field("writeback_sector", want.writeback_sector, got.writeback_sector);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] cmd = CMD_READ;
	logic [SECTOR_W-1:0] sector = '0;
	logic [OFS_W-1:0] byte_offset = '0;
	logic [OFS_W-1:0] byte_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic [SLOT_W-1:0] slot;
	logic fetch;
	logic writeback;
	logic [SECTOR_W-1:0] writeback_sector;
	logic last;

	cache_tag_tracker tracker = new();
	int send_idle_pct = 6;
	int recv_stall_pct = 68;
	bit hold_go = 1'b0;
	int hold_left = 0;
	logic [SECTOR_W-1:0] sector_pool [POOL_SIZE];

	sector_cache_clock_replacer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.sector(sector),
		.byte_offset(byte_offset),
		.byte_count(byte_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.slot(slot),
		.fetch(fetch),
		.writeback(writeback),
		.writeback_sector(writeback_sector),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// result side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			tracker.check_result('{hit: hit, slot: slot, fetch: fetch, writeback: writeback,
				writeback_sector: writeback_sector, last: last});
		if (hold_go) begin
			hold_left = 400;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_request(input logic [CMD_W-1:0] op, input logic [SECTOR_W-1:0] sec,
			input logic [OFS_W-1:0] ofs, input logic [OFS_W-1:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		sector <= sec;
		byte_offset <= ofs;
		byte_count <= cnt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_request(op, sec, ofs, cnt);
	endtask

	task automatic random_request();
		int pick;
		logic [CMD_W-1:0] op;
		logic [SECTOR_W-1:0] sec;
		logic [OFS_W-1:0] ofs, cnt;
		pick = $urandom_range(99);
		if (pick < 42)
			op = CMD_READ;
		else if (pick < 86)
			op = CMD_WRITE;
		else if (pick < 95)
			op = CMD_FLUSH;
		else
			op = CMD_NONE;
		pick = $urandom_range(99);
		if (pick < 85)
			sec = sector_pool[$urandom_range(POOL_SIZE - 1)];
		else
			sec = $urandom;
		pick = $urandom_range(99);
		if (pick < 30) begin
			ofs = '0;
			cnt = OFS_W'(SECTOR_SIZE);
		end else if (pick < 40) begin
			ofs = '0;
			cnt = OFS_W'($urandom_range(1023, 500));
		end else begin
			ofs = OFS_W'($urandom_range(1023));
			cnt = OFS_W'($urandom_range(1023));
		end
		send_request(op, sec, ofs, cnt);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		foreach (sector_pool[i])
			sector_pool[i] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, full and partial writes, hits, flushes
		send_request(CMD_READ, 32'h0000_0000, 10'd0, 10'd0);
		send_request(CMD_READ, 32'hFFFF_FFFF, 10'd1023, 10'd1023);
		send_request(CMD_WRITE, 32'h0000_0001, 10'd0, 10'd512);
		send_request(CMD_WRITE, 32'h0000_0002, 10'd0, 10'd1023);
		send_request(CMD_WRITE, 32'h0000_0003, 10'd1, 10'd512);
		send_request(CMD_WRITE, 32'h0000_0004, 10'd0, 10'd511);
		send_request(CMD_READ, 32'h0000_0001, 10'd512, 10'd1);
		send_request(CMD_WRITE, 32'h0000_0000, 10'd0, 10'd0);
		send_request(CMD_WRITE, 32'hFFFF_FFFF, 10'd512, 10'd512);
		send_request(CMD_FLUSH, 32'hFFFF_FFFF, 10'd1023, 10'd1023);
		send_request(CMD_FLUSH, 32'h0000_0000, 10'd0, 10'd0);
		send_request(CMD_NONE, 32'hA5A5_A5A5, 10'd512, 10'd512);
		send_request(CMD_READ, 32'h5A5A_5A5A, 10'h2AA, 10'h155);
		send_request(CMD_WRITE, 32'h0000_0001, 10'h155, 10'h2AA);

		// every entry dirty and referenced, then misses force the extra rotation
		for (int k = 0; k < 70; k++)
			send_request(CMD_WRITE, 32'h8000_0000 + k, 10'($urandom_range(1023)),
				10'($urandom_range(1023)));
		send_request(CMD_READ, 32'h7FFF_FFFF, 10'd0, 10'd512);
		send_request(CMD_WRITE, 32'h7FFF_FFFE, 10'd0, 10'd512);
		send_request(CMD_FLUSH, 32'h0, 10'd0, 10'd0);

		// long receiver hold-off while requests keep coming
		hold_go = 1'b1;
		repeat (10)
			random_request();
		repeat (60)
			random_request();

		send_idle_pct = 68;
		recv_stall_pct = 6;
		repeat (40)
			random_request();
		drain_results();
		repeat (40)
			random_request();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (73)
			random_request();

		drain_results();
		repeat (300)
			@(posedge clk);
		$display("covered %0d requests: %0d hits, %0d misses, %0d flushes", tracker.requests,
			tracker.hits, tracker.misses, tracker.flushes);
		$display("checked %0d results including %0d write-backs", tracker.results,
			tracker.writebacks);
		if (tracker.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/sccr_pkg.sv
hdl/sccr_ram.sv
hdl/sector_cache_clock_replacer.sv
sim/sector_cache_clock_replacer_test.sv
